FILE: design/tasp_pkg.sv
package tasp_pkg;

  localparam int ANGLE_FRAC_BITS = 12;
  localparam int ANGLE_WIDTH     = 24;
  localparam int COUNT_WIDTH     = 32;
  localparam int SPD_WIDTH       = 23;
  localparam int CMD_WIDTH       = 2;
  localparam int MAG_WIDTH       = ANGLE_WIDTH + 1;
  // 1e6 * maxdiff fits in MAG_WIDTH + 20 bits
  localparam int NUM_WIDTH       = MAG_WIDTH + 20;
  localparam int PROD_WIDTH      = MAG_WIDTH + 32;
  localparam int DIV_CNT_WIDTH   = 7;
  localparam int IN_DATA_WIDTH   = 80;
  localparam int OUT_DATA_WIDTH  = 48;
  localparam int OUT_USER_WIDTH  = 16;
  localparam int PADDR_WIDTH     = 4;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_TICK = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_SETP = 2'd2,
    CMD_BAD  = 2'd3
  } cmd_t;

  localparam logic [PADDR_WIDTH-1:0] REG_SPD_ADDR = 4'h0;
  localparam logic [PADDR_WIDTH-1:0] REG_PEN_ADDR = 4'h4;
  localparam logic [PADDR_WIDTH-1:0] REG_YEN_ADDR = 4'h8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_Y,
    ST_DIV_S,
    ST_DIV_C,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TICK,
    OP_SETP,
    OP_REJECT,
    OP_MUL_P,
    OP_MUL_Y,
    OP_LOAD_DIV_S,
    OP_LOAD_DIV_C,
    OP_FINISH_MOVE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic div_step;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic div_done;
    logic mc_zero;
    logic moving;
  } status_t;

endpackage

FILE: design/two_axis_step_pulse_mover_unit.sv
// channel  dir  handshake               payload
// in       in   in_tvalid/in_tready     tdata: cmd, target_pitch, target_yaw, speed
// out      out  out_tvalid/out_tready   tdata: positions; tuser: flags
// cfg      in   APB psel/penable/pwrite steps_per_degree, pitch_enable, yaw_enable
// A tick, set-position or rejected command shows its result the cycle after acceptance.
// A move shows its result after the pitch and yaw multiply states and two restoring
// divisions (1e6*diff/speed, then /count); the second is skipped when no steps are due.
// One item is in work at a time; in_tready is low until its result is taken.
// rst_n is synchronous; positions, counters, moving and directions clear to zero.
module two_axis_step_pulse_mover_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // cmd[1:0], target_pitch[25:2], target_yaw[49:26], speed[72:50], zero padding
  input  logic [tasp_pkg::IN_DATA_WIDTH-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // pitch_position, yaw_position
  output logic [tasp_pkg::OUT_DATA_WIDTH-1:0]  out_tdata,
  // step_pitch, step_yaw, dir_left_reverse, dir_right_reverse, dir_yaw_reverse,
  // pitch_enable_n, yaw_enable_n, busy_res, rejected, zero padding
  output logic [tasp_pkg::OUT_USER_WIDTH-1:0]  out_tuser,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [tasp_pkg::PADDR_WIDTH-1:0]     cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);
  import tasp_pkg::*;

  logic [31:0] spd_deg_r;
  logic pen_r, yen_r;
  ctrl_t ctrl;
  status_t status;
  logic in_fire, out_fire, step_p, step_y, rej;
  logic [2:0] dirs;
  logic signed [ANGLE_WIDTH-1:0] pos_p, pos_y;
  cmd_t cmd;

  assign cfg_pready = 1'b1;
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign cmd = cmd_t'(in_tdata[1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_deg_r <= 32'd582542; pen_r <= 1'b0; yen_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == REG_SPD_ADDR) spd_deg_r <= cfg_pwdata;
      if (cfg_paddr == REG_PEN_ADDR) pen_r <= cfg_pwdata[0];
      if (cfg_paddr == REG_YEN_ADDR) yen_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == REG_SPD_ADDR) cfg_prdata = spd_deg_r;
    else if (cfg_paddr == REG_PEN_ADDR) cfg_prdata = {31'd0, pen_r};
    else if (cfg_paddr == REG_YEN_ADDR) cfg_prdata = {31'd0, yen_r};
  end

  tasp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .cmd(cmd),
    .spd_zero(in_tdata[72:50] == '0), .out_fire(out_fire), .status(status),
    .ctrl(ctrl), .in_ready(in_tready), .out_valid(out_tvalid)
  );

  // input fields are held stable by the handshake only at accept; latch them
  logic signed [ANGLE_WIDTH-1:0] tp_r, ty_r;
  logic [SPD_WIDTH-1:0] sp_r;
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tp_r <= in_tdata[25:2]; ty_r <= in_tdata[49:26]; sp_r <= in_tdata[72:50];
    end
  end

  tasp_dp u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
    .tgt_p(in_fire ? $signed(in_tdata[25:2]) : tp_r),
    .tgt_y(in_fire ? $signed(in_tdata[49:26]) : ty_r),
    .spd(sp_r), .steps_per_degree(spd_deg_r), .status(status),
    .step_p(step_p), .step_y(step_y), .dirs(dirs), .rej(rej),
    .pos_p(pos_p), .pos_y(pos_y)
  );

  assign out_tdata = {pos_y, pos_p};
  assign out_tuser = {7'd0, rej, status.moving, ~yen_r, ~pen_r, dirs, step_y, step_p};

endmodule

FILE: design/tasp_ctrl.sv
module tasp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  tasp_pkg::cmd_t    cmd,
  input  logic              spd_zero,
  input  logic              out_fire,
  input  tasp_pkg::status_t status,
  output tasp_pkg::ctrl_t   ctrl,
  output logic              in_ready,
  output logic              out_valid
);
  import tasp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (cmd == CMD_MOVE && !status.moving && !spd_zero) begin
            state_nxt = ST_MUL_P;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_MUL_P: state_nxt = ST_MUL_Y;
      ST_MUL_Y: state_nxt = ST_DIV_S;
      ST_DIV_S: begin
        if (status.div_done) begin
          state_nxt = status.mc_zero ? ST_OUT : ST_DIV_C;
        end
      end
      ST_DIV_C: begin
        if (status.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '{op: OP_NONE, div_step: 1'b0, out_load: 1'b0};
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          ctrl.out_load = 1'b1;
          priority case (1'b1)
            cmd == CMD_TICK: ctrl.op = OP_TICK;
            cmd == CMD_MOVE && !status.moving && !spd_zero: ctrl.op = OP_NONE;
            cmd == CMD_SETP && !status.moving: ctrl.op = OP_SETP;
            default: ctrl.op = OP_REJECT;
          endcase
          if (cmd == CMD_MOVE && !status.moving && !spd_zero) begin
            ctrl.out_load = 1'b0;
          end
        end
      end
      ST_MUL_P: ctrl.op = OP_MUL_P;
      ST_MUL_Y: ctrl.op = OP_MUL_Y;
      ST_DIV_S: begin
        ctrl.div_step = 1'b1;
        if (status.div_done) begin
          ctrl.op = status.mc_zero ? OP_FINISH_MOVE : OP_LOAD_DIV_C;
          ctrl.out_load = status.mc_zero;
        end
      end
      ST_DIV_C: begin
        ctrl.div_step = 1'b1;
        if (status.div_done) begin
          ctrl.op = OP_FINISH_MOVE;
          ctrl.out_load = 1'b1;
        end
      end
      ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("ready while working");
  a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |=> out_valid) else $error("result not shown after load");
  a_div_only_move: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.div_step |-> (state_r == ST_DIV_S || state_r == ST_DIV_C))
    else $error("divider stepped outside move");
`endif

endmodule

FILE: design/tasp_dp.sv
module tasp_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tasp_pkg::ctrl_t                        ctrl,
  input  logic signed [tasp_pkg::ANGLE_WIDTH-1:0] tgt_p,
  input  logic signed [tasp_pkg::ANGLE_WIDTH-1:0] tgt_y,
  input  logic [tasp_pkg::SPD_WIDTH-1:0]          spd,
  input  logic [31:0]                            steps_per_degree,
  output tasp_pkg::status_t                      status,
  output logic                                   step_p,
  output logic                                   step_y,
  output logic [2:0]                             dirs,
  output logic                                   rej,
  output logic signed [tasp_pkg::ANGLE_WIDTH-1:0] pos_p,
  output logic signed [tasp_pkg::ANGLE_WIDTH-1:0] pos_y
);
  import tasp_pkg::*;

  logic signed [ANGLE_WIDTH-1:0] pang_r, pang_nxt, yang_r, yang_nxt;
  logic signed [ANGLE_WIDTH-1:0] pgoal_r, pgoal_nxt, ygoal_r, ygoal_nxt;
  logic [COUNT_WIDTH-1:0] pcnt_r, pcnt_nxt, ycnt_r, ycnt_nxt;
  logic [31:0] iter_r, iter_nxt, per_r, per_nxt, wait_r, wait_nxt;
  logic moving_r, moving_nxt;
  logic [2:0] dirs_r, dirs_nxt;
  logic signed [MAG_WIDTH-1:0] dp_r, dp_nxt, dy_r, dy_nxt;
  logic [MAG_WIDTH-1:0] mp, my, md, mag_sel;
  logic [PROD_WIDTH-1:0] prod;
  logic [PROD_WIDTH-ANGLE_FRAC_BITS-17:0] cfull;
  logic [COUNT_WIDTH-1:0] csat, mc;
  logic [NUM_WIDTH-1:0] quo_r, quo_nxt, rem_r, rem_nxt;
  logic [NUM_WIDTH:0] rem_sh;
  logic [NUM_WIDTH-1:0] dvs_r, dvs_nxt;
  logic [DIV_CNT_WIDTH-1:0] dcnt_r, dcnt_nxt;
  logic step_p_r, step_p_nxt, step_y_r, step_y_nxt, rej_r, rej_nxt;
  logic [31:0] wait_after, iter_after;
  logic [NUM_WIDTH-1:0] pclamp;
  logic sp, sy;

  assign mp = dp_r[MAG_WIDTH-1] ? MAG_WIDTH'(-dp_r) : MAG_WIDTH'(dp_r);
  assign my = dy_r[MAG_WIDTH-1] ? MAG_WIDTH'(-dy_r) : MAG_WIDTH'(dy_r);
  assign md = (mp > my) ? mp : my;
  assign mc = (pcnt_r > ycnt_r) ? pcnt_r : ycnt_r;
  assign mag_sel = (ctrl.op == OP_MUL_P) ? mp : my;
  // Q16.16 product then drop fraction bits; the hi/lo split of the scale gives the same floor
  assign prod = PROD_WIDTH'(mag_sel) * PROD_WIDTH'(steps_per_degree);
  assign cfull = prod[PROD_WIDTH-1:ANGLE_FRAC_BITS+16];
  assign csat = (cfull > (PROD_WIDTH-ANGLE_FRAC_BITS-16)'({COUNT_WIDTH{1'b1}}))
                ? {COUNT_WIDTH{1'b1}} : COUNT_WIDTH'(cfull);
  assign rem_sh = {rem_r, quo_r[NUM_WIDTH-1]};
  assign pclamp = (quo_r == '0) ? NUM_WIDTH'(1)
                : (quo_r > NUM_WIDTH'(32'hFFFF_FFFF)) ? NUM_WIDTH'(32'hFFFF_FFFF) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pang_r <= '0; yang_r <= '0; pgoal_r <= '0; ygoal_r <= '0;
      pcnt_r <= '0; ycnt_r <= '0; iter_r <= '0; per_r <= '0; wait_r <= '0;
      moving_r <= 1'b0; dirs_r <= '0;
    end else begin
      pang_r <= pang_nxt; yang_r <= yang_nxt; pgoal_r <= pgoal_nxt; ygoal_r <= ygoal_nxt;
      pcnt_r <= pcnt_nxt; ycnt_r <= ycnt_nxt; iter_r <= iter_nxt; per_r <= per_nxt;
      wait_r <= wait_nxt; moving_r <= moving_nxt; dirs_r <= dirs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dp_r <= dp_nxt; dy_r <= dy_nxt; quo_r <= quo_nxt; rem_r <= rem_nxt;
    dvs_r <= dvs_nxt; dcnt_r <= dcnt_nxt;
    step_p_r <= step_p_nxt; step_y_r <= step_y_nxt; rej_r <= rej_nxt;
  end

  always_comb begin
    sp = 1'b0; sy = 1'b0;
    iter_after = iter_r; wait_after = wait_r;
    if (wait_r == '0) begin
      sp = COUNT_WIDTH'(iter_r) < pcnt_r;
      sy = COUNT_WIDTH'(iter_r) < ycnt_r;
      iter_after = iter_r + 32'd1;
      wait_after = per_r - 32'd1;
    end else begin
      wait_after = wait_r - 32'd1;
    end
  end

  always_comb begin
    pang_nxt = pang_r; yang_nxt = yang_r; pgoal_nxt = pgoal_r; ygoal_nxt = ygoal_r;
    pcnt_nxt = pcnt_r; ycnt_nxt = ycnt_r; iter_nxt = iter_r; per_nxt = per_r;
    wait_nxt = wait_r; moving_nxt = moving_r; dirs_nxt = dirs_r;
    dp_nxt = dp_r; dy_nxt = dy_r; quo_nxt = quo_r; rem_nxt = rem_r;
    dvs_nxt = dvs_r; dcnt_nxt = dcnt_r;
    step_p_nxt = step_p_r; step_y_nxt = step_y_r; rej_nxt = rej_r;
    if (ctrl.out_load) begin
      step_p_nxt = 1'b0; step_y_nxt = 1'b0; rej_nxt = 1'b0;
    end
    unique case (ctrl.op)
      OP_TICK: begin
        if (moving_r) begin
          step_p_nxt = sp; step_y_nxt = sy;
          iter_nxt = iter_after; wait_nxt = wait_after;
          if (wait_after == '0 && COUNT_WIDTH'(iter_after) >= pcnt_r
              && COUNT_WIDTH'(iter_after) >= ycnt_r) begin
            if (pcnt_r != '0) pang_nxt = pgoal_r;
            if (ycnt_r != '0) yang_nxt = ygoal_r;
            moving_nxt = 1'b0;
          end
        end
      end
      OP_SETP: begin
        pang_nxt = tgt_p; yang_nxt = tgt_y;
      end
      OP_REJECT: rej_nxt = 1'b1;
      OP_NONE: begin
        // latch differences on any cycle with no other op, which covers a move's accept
        dp_nxt = MAG_WIDTH'(tgt_p) - MAG_WIDTH'(pang_r);
        dy_nxt = MAG_WIDTH'(tgt_y) - MAG_WIDTH'(yang_r);
      end
      OP_MUL_P: pcnt_nxt = csat;
      OP_MUL_Y: begin
        ycnt_nxt = csat;
        pgoal_nxt = tgt_p; ygoal_nxt = tgt_y;
        iter_nxt = '0; wait_nxt = '0;
        quo_nxt = NUM_WIDTH'(md) * NUM_WIDTH'(20'd1000000);
        rem_nxt = '0;
        dvs_nxt = NUM_WIDTH'(spd);
        dcnt_nxt = '0;
      end
      OP_LOAD_DIV_C: begin
        rem_nxt = '0;
        dvs_nxt = NUM_WIDTH'(mc);
        dcnt_nxt = '0;
      end
      OP_FINISH_MOVE: begin
        dirs_nxt[0] = !(pcnt_r != '0 && !dp_r[MAG_WIDTH-1] && dp_r != '0);
        dirs_nxt[1] = pcnt_r != '0 && !dp_r[MAG_WIDTH-1] && dp_r != '0;
        dirs_nxt[2] = ycnt_r != '0 && dy_r[MAG_WIDTH-1];
        if (!status.mc_zero) begin
          per_nxt = pclamp[31:0];
          moving_nxt = 1'b1;
        end
      end
      default: ;
    endcase
    // restoring division, one quotient bit a cycle
    if (ctrl.div_step && !status.div_done) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = NUM_WIDTH'(rem_sh - {1'b0, dvs_r});
        quo_nxt = {quo_r[NUM_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[NUM_WIDTH-1:0];
        quo_nxt = {quo_r[NUM_WIDTH-2:0], 1'b0};
      end
      dcnt_nxt = dcnt_r + DIV_CNT_WIDTH'(1);
    end
  end

  assign status.div_done = (dcnt_r == DIV_CNT_WIDTH'(NUM_WIDTH));
  assign status.mc_zero  = (mc == '0);
  assign status.moving   = moving_r;
  assign step_p = step_p_r;
  assign step_y = step_y_r;
  assign dirs   = dirs_r;
  assign rej    = rej_r;
  assign pos_p  = pang_r;
  assign pos_y  = yang_r;

`ifndef ASSERT_OFF
  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r |-> (per_r != '0)) else $error("zero period while moving");
  a_step_needs_move: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_TICK && !moving_r) |=> (!step_p_r && !step_y_r))
    else $error("step while idle");
  a_dir_excl: assert property (@(posedge clk) disable iff (!rst_n)
    dirs_r[0] != dirs_r[1] || (dirs_r[1:0] == 2'b00 && !moving_r))
    else $error("pitch directions not exclusive");
`endif

endmodule

FILE: tb/sv/two_axis_step_pulse_mover_unit_test.sv
module two_axis_step_pulse_mover_unit_test;
  import tasp_pkg::*;

  typedef struct packed {
    logic        step_pitch;
    logic        step_yaw;
    logic        dir_left_rev;
    logic        dir_right_rev;
    logic        dir_yaw_rev;
    logic        pitch_en_n;
    logic        yaw_en_n;
    logic        busy;
    logic        rejected;
    logic [23:0] pitch_pos;
    logic [23:0] yaw_pos;
  } mover_out_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [OUT_DATA_WIDTH-1:0] out_tdata;
  logic [OUT_USER_WIDTH-1:0] out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [PADDR_WIDTH-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  two_axis_step_pulse_mover_unit dut (.*);

  // mirror of the mover state
  logic [31:0] spd_per_deg;
  logic        pitch_on, yaw_on;
  logic signed [23:0] cur_pitch, cur_yaw, goal_pitch, goal_yaw;
  longint      pitch_steps, yaw_steps, iter_no, step_period, wait_cnt;
  bit          moving;
  logic [2:0]  dir_bits;

  mover_out_t  pending_outs[$];
  int          fails = 0;
  int          items_sent = 0;
  int          moves_started = 0;
  int          hold_left = 0;
  bit          quiet = 0;
  int          idle_cycles = 0;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint steps_for(input longint mag);
    longint c;
    c = (mag * longint'(spd_per_deg[31:16]) + ((mag * longint'(spd_per_deg[15:0])) >> 16))
        >> ANGLE_FRAC_BITS;
    return (c > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : c;
  endfunction

  function automatic mover_out_t advance_mover(input cmd_t c, input logic [23:0] tp,
                                               input logic [23:0] ty, input logic [22:0] spd);
    mover_out_t r;
    longint dp, dy, mp, my, cp, cy, md, mc, p;
    bit pos;
    r = '0;
    case (c)
      CMD_TICK: if (moving) begin
        if (wait_cnt == 0) begin
          r.step_pitch = iter_no < pitch_steps;
          r.step_yaw = iter_no < yaw_steps;
          iter_no = (iter_no + 1) & 64'hFFFF_FFFF;
          wait_cnt = step_period - 1;
        end else begin
          wait_cnt--;
        end
        if (wait_cnt == 0 && iter_no >= pitch_steps && iter_no >= yaw_steps) begin
          if (pitch_steps > 0) cur_pitch = goal_pitch;
          if (yaw_steps > 0) cur_yaw = goal_yaw;
          moving = 0;
        end
      end
      CMD_MOVE: if (moving || spd == 0) begin
        r.rejected = 1;
      end else begin
        dp = longint'($signed(tp)) - longint'(cur_pitch);
        dy = longint'($signed(ty)) - longint'(cur_yaw);
        mp = dp < 0 ? -dp : dp;
        my = dy < 0 ? -dy : dy;
        cp = steps_for(mp);
        cy = steps_for(my);
        md = mp > my ? mp : my;
        mc = cp > cy ? cp : cy;
        pos = cp > 0 && dp > 0;
        dir_bits = {cy > 0 && dy < 0, pos, !pos};
        goal_pitch = tp;
        goal_yaw = ty;
        pitch_steps = cp;
        yaw_steps = cy;
        iter_no = 0;
        wait_cnt = 0;
        if (mc > 0) begin
          p = ((64'd1000000 * md) / longint'(spd)) / mc;
          if (p < 1) p = 1;
          if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
          step_period = p;
          moving = 1;
          moves_started++;
        end
      end
      CMD_SETP: if (moving) begin
        r.rejected = 1;
      end else begin
        cur_pitch = tp;
        cur_yaw = ty;
      end
      default: r.rejected = 1;
    endcase
    r.dir_left_rev = dir_bits[0];
    r.dir_right_rev = dir_bits[1];
    r.dir_yaw_rev = dir_bits[2];
    r.pitch_en_n = !pitch_on;
    r.yaw_en_n = !yaw_on;
    r.busy = moving;
    r.pitch_pos = cur_pitch;
    r.yaw_pos = cur_yaw;
    return r;
  endfunction

  task automatic send_item(input cmd_t c, input logic [23:0] tp, input logic [23:0] ty,
                           input logic [22:0] spd);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {7'b0, spd, ty, tp, c};
    do @(posedge clk); while (!in_tready);
    pending_outs.push_back(advance_mover(c, tp, ty, spd));
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [PADDR_WIDTH-1:0] addr, input logic [31:0] val);
    // only touch the registers while no item is in the block
    wait (pending_outs.size() == 0);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_penable = 1'b0;
    cfg_paddr = addr; cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    if (addr == REG_SPD_ADDR) spd_per_deg = val;
    else if (addr == REG_PEN_ADDR) pitch_on = val[0];
    else if (addr == REG_YEN_ADDR) yaw_on = val[0];
  endtask

  // tick until the mirrored move is over or max_ticks run out, then let the block go quiet
  task automatic settle(input int max_ticks);
    int n;
    n = 0;
    while (moving && n < max_ticks) begin
      send_item(CMD_TICK, 24'($urandom), 24'($urandom), 23'($urandom));
      n++;
    end
    wait (pending_outs.size() == 0);
    repeat (120) @(negedge clk);
  endtask

  task automatic test_directed();
    send_item(CMD_TICK, 24'h0, 24'h0, 23'h0);
    send_item(CMD_BAD, 24'hFFFFFF, 24'hFFFFFF, 23'h7FFFFF);
    send_item(CMD_MOVE, 24'd4096, 24'd4096, 23'd0);
    send_item(CMD_SETP, 24'h800000, 24'h7FFFFF, 23'h0);
    // no steps: zero scale latches directions only
    write_reg(REG_SPD_ADDR, 32'h0);
    send_item(CMD_MOVE, 24'h7FFFFF, 24'h800000, 23'h7FFFFF);
    send_item(CMD_SETP, 24'h0, 24'h0, 23'h0);
    write_reg(REG_SPD_ADDR, 32'hFFFF_FFFF);
    // period clamps up to one tick
    send_item(CMD_MOVE, 24'd1, -24'sd1, 23'h7FFFFF);
    send_item(CMD_MOVE, 24'd5, 24'd5, 23'd100);
    send_item(CMD_SETP, 24'd9, 24'd9, 23'd0);
    settle(100);
    write_reg(REG_SPD_ADDR, 32'd582542);
    send_item(CMD_MOVE, -24'sd500, 24'd700, 23'd7000000);
    send_item(CMD_MOVE, 24'd2000, 24'd0, 23'h400000);
    send_item(CMD_TICK, 24'h0, 24'h0, 23'h0);
    send_item(CMD_TICK, 24'h0, 24'h0, 23'h0);
    settle(600);
    send_item(CMD_MOVE, 24'd0, 24'd0, 23'h7FFFFF);
    settle(600);
  endtask

  task automatic random_ops(input int count);
    longint t1, t2, d1, d2;
    int pick;
    cmd_t c;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_item(CMD_SETP, 24'($urandom), 24'($urandom), 23'($urandom));
      end else if (pick < 20) begin
        // noise: bad code, zero speed, busy collisions, null moves
        c = cmd_t'($urandom_range(1, 3));
        if (c == CMD_MOVE && !moving && $urandom_range(0, 1))
          send_item(CMD_MOVE, cur_pitch, cur_yaw, 23'($urandom));
        else
          send_item(c, 24'($urandom), 24'($urandom),
                    (c == CMD_MOVE && !moving) ? 23'd0 : 23'($urandom));
      end else begin
        d1 = $signed($urandom_range(0, 200)) - 100;
        d2 = $signed($urandom_range(0, 200)) - 100;
        t1 = longint'(cur_pitch) + d1;
        t2 = longint'(cur_yaw) + d2;
        if (t1 > 8388607 || t1 < -8388608) t1 = longint'(cur_pitch) - d1;
        if (t2 > 8388607 || t2 < -8388608) t2 = longint'(cur_yaw) - d2;
        send_item(CMD_MOVE, 24'(t1), 24'(t2), 23'($urandom_range(4194304, 8388607)));
        while (moving && $urandom_range(0, 30) != 0)
          send_item(CMD_TICK, 24'($urandom), 24'($urandom), 23'($urandom));
      end
    end
  endtask

  task automatic test_scales();
    write_reg(REG_PEN_ADDR, 32'd1);
    random_ops(100);
    settle(300);
    write_reg(REG_SPD_ADDR, 32'h0064_0000);
    write_reg(REG_YEN_ADDR, 32'd1);
    random_ops(20);
    settle(300);
    write_reg(REG_SPD_ADDR, 32'h0100_0000);
    write_reg(REG_PEN_ADDR, 32'd0);
    random_ops(20);
    settle(300);
  endtask

  task automatic test_backpressure();
    write_reg(REG_YEN_ADDR, 32'd0);
    send_item(CMD_MOVE, cur_pitch + 24'd40, cur_yaw - 24'd40, 23'h7FFFFF);
    hold_left = 300;
    repeat (25) send_item(CMD_TICK, 24'h0, 24'h0, 23'h0);
    settle(300);
  endtask

  task automatic test_quiet_tail();
    quiet = 1;
    write_reg(REG_SPD_ADDR, 32'h00FF_FFFF);
    write_reg(REG_PEN_ADDR, 32'd1);
    random_ops(20);
    settle(300);
  endtask

  function automatic void check_field(input string name, input longint exp_v,
                                      input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outs.size() == 0) begin
        $error("result with no item waiting for it");
        fails++;
      end else begin
        mover_out_t e;
        e = pending_outs.pop_front();
        check_field("step_pitch", e.step_pitch, out_tuser[0]);
        check_field("step_yaw", e.step_yaw, out_tuser[1]);
        check_field("dir_left_reverse", e.dir_left_rev, out_tuser[2]);
        check_field("dir_right_reverse", e.dir_right_rev, out_tuser[3]);
        check_field("dir_yaw_reverse", e.dir_yaw_rev, out_tuser[4]);
        check_field("pitch_enable_n", e.pitch_en_n, out_tuser[5]);
        check_field("yaw_enable_n", e.yaw_en_n, out_tuser[6]);
        check_field("busy_res", e.busy, out_tuser[7]);
        check_field("rejected", e.rejected, out_tuser[8]);
        check_field("pitch_position", e.pitch_pos, out_tdata[23:0]);
        check_field("yaw_position", e.yaw_pos, out_tdata[47:24]);
      end
    end
  end

  // receiver: long hold on request, else random stall bursts
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("two_axis_step_pulse_mover_unit regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    spd_per_deg = 32'd582542; pitch_on = 0; yaw_on = 0;
    cur_pitch = 0; cur_yaw = 0; goal_pitch = 0; goal_yaw = 0;
    pitch_steps = 0; yaw_steps = 0; iter_no = 0; step_period = 0; wait_cnt = 0;
    moving = 0; dir_bits = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_scales();
    test_backpressure();
    test_quiet_tail();
    wait (pending_outs.size() == 0);
    repeat (150) @(posedge clk);
    $display("Covered %0d items (%0d moves that stepped) over six scale settings,",
             items_sent, moves_started);
    $display("both enable levels, rejections, null moves and a long output stall.");
    if (fails == 0 && pending_outs.size() == 0)
      $display("two_axis_step_pulse_mover_unit regression: pass");
    else
      $display("two_axis_step_pulse_mover_unit regression: fail");
    $finish;
  end

endmodule
